@@ rtl/abm_pkg.sv @@
// Shared types, constants and state codes of the audio bar meter.
`default_nettype none

package abm_pkg;

  // Default sizing of the meter
  localparam int COLUMNS_DEF     = 128;
  localparam int POINTS_DEF      = 512;
  localparam int HOLD_FRAMES_DEF = 500;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed field widths
  localparam int STEP_W    = 13;
  localparam int DCOUNT_W  = 12;
  localparam int LEVEL_W   = 16;
  localparam int COL_IDX_W = 7;
  localparam int SUM_W     = 32;

  localparam logic [STEP_W-1:0] STEP_MAX = 13'd4096;
  localparam logic [STEP_W-1:0] STEP_MIN = 13'd1;

  // 1.5e-7 in unsigned Q48
  localparam int SCALE_W = 26;
  localparam logic [SCALE_W-1:0] SCALE_Q48 = 26'd42221247;

  // Log2 unit: integer part, fraction and mantissa widths
  localparam int LOG_INT_W  = 6;
  localparam int LOG_FRAC_W = 16;
  localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
  localparam int MANT_W     = 32;
  localparam int WORD_W     = 64;
  localparam int NORM_STEPS = 6;

  // Signed width for the exponent compare
  localparam int CMP_W = 30;
  localparam logic [CMP_W-1:0] LIM_OFFSET = 30'd9961472;  // 152 * 2^16

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
  } abm_pw_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] level;
  } abm_pw_rsp_t;

  typedef enum logic [2:0] {
    PW_IDLE,
    PW_SCALE,
    PW_NORM,
    PW_SQUARE,
    PW_DECIDE,
    PW_DONE
  } pw_state_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POWER,
    ST_DIV_MUL,
    ST_DIV_BACK,
    ST_DIV_FIX,
    ST_WRITE,
    ST_SWEEP
  } top_state_t;

endpackage

`default_nettype wire

@@ rtl/abm_power.sv @@
// Power-law level unit: scale a column sum and raise it to 0.45 via log2 bisection.
`default_nettype none

module abm_power (
  input  logic                clk,
  input  logic                rst_n,
  input  abm_pkg::abm_pw_req_t req,
  output abm_pkg::abm_pw_rsp_t rsp
);
  import abm_pkg::*;

  localparam int SC_W = SUM_W - 1 + SCALE_W;

  pw_state_t state_r, state_nxt;

  logic signed [SUM_W-1:0]  sum_r;
  logic [WORD_W-1:0]        v_r;
  logic [LOG_INT_W-1:0]     p_r;
  logic [2:0]               k_r;
  logic [3:0]               sq_cnt_r;
  logic [MANT_W-1:0]        m_r;
  logic [LOG_FRAC_W-1:0]    frac_r;
  logic                     is_x_r;
  logic signed [CMP_W-1:0]  lim_r;
  logic [LEVEL_W-1:0]       lo_r, hi_r, mid_r, res_r;

  logic                     sum_pos;
  logic [SC_W-1:0]          prod_sc;
  logic [5:0]               shamt;
  logic [WORD_W-1:0]        top_mask;
  logic                     top_zero;
  logic [WORD_W-1:0]        v_nxt;
  logic [LOG_INT_W-1:0]     p_nxt;
  logic [2*MANT_W-1:0]      sq;
  logic [MANT_W:0]          sq_top;
  logic [MANT_W-1:0]        m_nxt;
  logic [LOG_W-1:0]         log_v;
  logic [CMP_W-1:0]         l_ext;
  logic [CMP_W-1:0]         lim_calc;
  logic [CMP_W-1:0]         t20;
  logic                     pass;
  logic [LEVEL_W-1:0]       lo_n, hi_n, mid_n;
  logic [LEVEL_W:0]         mid_sum;

  assign sum_pos = !sum_r[SUM_W-1] && (sum_r != '0);
  assign prod_sc = {{SCALE_W{1'b0}}, sum_r[SUM_W-2:0]} * {{(SUM_W-1){1'b0}}, SCALE_Q48};

  // Leading-zero search, halving the step each cycle
  assign shamt    = 6'd32 >> k_r;
  assign top_mask = ~({WORD_W{1'b1}} >> shamt);
  assign top_zero = (v_r & top_mask) == '0;
  assign v_nxt    = top_zero ? (v_r << shamt) : v_r;
  assign p_nxt    = top_zero ? (p_r - shamt) : p_r;

  // One mantissa squaring per cycle
  assign sq     = {{MANT_W{1'b0}}, m_r} * {{MANT_W{1'b0}}, m_r};
  assign sq_top = sq[2*MANT_W-1:MANT_W-1];
  assign m_nxt  = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];

  assign log_v    = {p_r, frac_r};
  assign l_ext    = {{(CMP_W-LOG_W){1'b0}}, log_v};
  assign lim_calc = (l_ext << 3) + l_ext - LIM_OFFSET;
  assign t20      = (l_ext << 4) + (l_ext << 2);
  assign pass     = $signed(t20) <= lim_r;

  always_comb begin
    if (is_x_r) begin
      lo_n = '0;
      hi_n = '1;
    end else if (pass) begin
      lo_n = mid_r;
      hi_n = hi_r;
    end else begin
      lo_n = lo_r;
      hi_n = mid_r - 16'd1;
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n} + 17'd1;
    mid_n   = mid_sum[LEVEL_W:1];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PW_IDLE:   if (req.start) state_nxt = PW_SCALE;
      PW_SCALE:  state_nxt = sum_pos ? PW_NORM : PW_DONE;
      PW_NORM:   if (k_r == 3'(NORM_STEPS - 1)) state_nxt = PW_SQUARE;
      PW_SQUARE: if (sq_cnt_r == 4'(LOG_FRAC_W - 1)) state_nxt = PW_DECIDE;
      PW_DECIDE: state_nxt = (lo_n < hi_n) ? PW_NORM : PW_DONE;
      PW_DONE:   state_nxt = PW_IDLE;
      default:   state_nxt = PW_IDLE;
    endcase
  end

  always_comb begin
    rsp.done  = (state_r == PW_DONE);
    rsp.level = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PW_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      PW_IDLE: begin
        if (req.start) sum_r <= req.sum;
      end
      PW_SCALE: begin
        res_r  <= '0;
        v_r    <= {{(WORD_W-SC_W){1'b0}}, prod_sc};
        p_r    <= '1;
        k_r    <= '0;
        is_x_r <= 1'b1;
      end
      PW_NORM: begin
        v_r <= v_nxt;
        p_r <= p_nxt;
        k_r <= k_r + 3'd1;
        if (k_r == 3'(NORM_STEPS - 1)) begin
          m_r      <= v_nxt[WORD_W-1:WORD_W-MANT_W];
          frac_r   <= '0;
          sq_cnt_r <= '0;
        end
      end
      PW_SQUARE: begin
        m_r      <= m_nxt;
        frac_r   <= {frac_r[LOG_FRAC_W-2:0], sq_top[MANT_W]};
        sq_cnt_r <= sq_cnt_r + 4'd1;
      end
      PW_DECIDE: begin
        if (is_x_r) lim_r <= $signed(lim_calc);
        lo_r <= lo_n;
        hi_r <= hi_n;
        if (lo_n < hi_n) begin
          mid_r  <= mid_n;
          v_r    <= {{(WORD_W-LEVEL_W){1'b0}}, mid_n};
          p_r    <= '1;
          k_r    <= '0;
          is_x_r <= 1'b0;
        end else begin
          res_r <= lo_n;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/audio_bar_meter_peak_decay_top.sv @@
// Top level of the audio bar meter with peak hold and decay.
`default_nettype none

// Channel   Dir  Handshake              Payload
// in_       in   in_valid / in_stall    in_sample, in_frame_end
// out_      out  out_valid / out_stall  out_column_index, out_bar_level, out_last_column
// cfg_      in   cfg_wr_en              cfg_wr_data (decimation step)
//
// A sample that finishes no column and carries no frame end is taken without stalling the input.
// A sample that finishes a column stalls the input while the power unit runs
// 17 log2 evaluations (one for the scaled sum, 16 bisection probes), each 6
// normalize steps, 16 squarings on one 32x32 multiplier and a compare.
// A frame end adds the hold counter sweep over the memory.
// After reset a clearing pass zeroes the column memory; no transaction is
// accepted until it ends. A stalled result holds the write-back.

module audio_bar_meter_peak_decay_top #(
  parameter int COLUMNS     = abm_pkg::COLUMNS_DEF,
  parameter int POINTS      = abm_pkg::POINTS_DEF,
  parameter int HOLD_FRAMES = abm_pkg::HOLD_FRAMES_DEF,
  parameter int SAMPLE_BITS = abm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic                                 in_frame_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [abm_pkg::COL_IDX_W-1:0]        out_column_index,
  output logic [abm_pkg::LEVEL_W-1:0]          out_bar_level,
  output logic                                 out_last_column,
  input  logic                                 cfg_wr_en,
  input  logic [abm_pkg::STEP_W-1:0]           cfg_wr_data
);
  import abm_pkg::*;

  localparam int ADDR_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int COLCNT_W   = $clog2(COLUMNS + 1);
  localparam int PER_COLUMN = ((POINTS / COLUMNS) > 0) ? (POINTS / COLUMNS) : 1;
  localparam int KEEP_W     = $clog2(PER_COLUMN + 1);
  localparam int CNT_W      = $clog2(HOLD_FRAMES + 1);
  localparam int MEM_W      = LEVEL_W + CNT_W;
  localparam int PROD_W     = LEVEL_W + CNT_W;
  localparam int RECIP_SH   = PROD_W;
  localparam int RECIP_W    = PROD_W + 1;
  localparam int T_W        = PROD_W + RECIP_W;
  localparam int ADDR_EXT_W = (ADDR_W > COL_IDX_W) ? ADDR_W : COL_IDX_W;

  localparam logic [CNT_W-1:0]    HOLD_CNT  = CNT_W'(HOLD_FRAMES);
  localparam logic [RECIP_W-1:0]  RECIP     = RECIP_W'((64'd1 << RECIP_SH) / HOLD_FRAMES);
  localparam logic [COLCNT_W-1:0] COL_LIMIT = COLCNT_W'(COLUMNS);
  localparam logic [COLCNT_W-1:0] COL_LAST  = COLCNT_W'(COLUMNS - 1);
  localparam logic [KEEP_W:0]     KEEP_LIM  = (KEEP_W + 1)'(PER_COLUMN);

  top_state_t state_r, state_nxt;

  // Configuration
  logic [STEP_W-1:0]       step_r;
  logic [STEP_W-1:0]       step_eff;

  // Frame position
  logic [DCOUNT_W-1:0]     dcount_r;
  logic [KEEP_W-1:0]       kept_r;
  logic [COLCNT_W-1:0]     cur_col_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                    sweep_pend_r;
  logic [COLCNT_W-1:0]     sw_r;

  // Column update
  logic [ADDR_W-1:0]       col_r;
  logic                    last_r;
  logic [LEVEL_W-1:0]      new_lvl_r;
  logic [CNT_W-1:0]        new_cnt_r;
  logic [PROD_W-1:0]       prod_r;
  logic [T_W-1:0]          t_r;
  logic [LEVEL_W-1:0]      q0_r;
  logic [PROD_W-1:0]       qh_r;

  // Column memory: {level, hold counter}
  logic [MEM_W-1:0]        mem [COLUMNS];
  logic [MEM_W-1:0]        rdata_r;
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_wa, mem_ra;
  logic [MEM_W-1:0]        mem_wd;

  // Output register
  logic                    out_valid_r;
  logic [COL_IDX_W-1:0]    out_col_r;
  logic [LEVEL_W-1:0]      out_lvl_r;
  logic                    out_last_r;
  logic                    out_free;
  logic                    out_load;

  abm_pw_req_t             pw_req;
  abm_pw_rsp_t             pw_rsp;

  logic                    in_acc;
  logic                    col_active;
  logic                    keep;
  logic [DCOUNT_W:0]       dcount_inc;
  logic                    dcount_wrap;
  logic [KEEP_W:0]         kept_inc;
  logic                    col_done;
  logic [SUM_W:0]          sample_ext;
  logic [SUM_W:0]          sum_add;
  logic                    sum_ovf;
  logic [SUM_W-1:0]        sum_sat;
  logic [LEVEL_W-1:0]      rd_lvl;
  logic [CNT_W-1:0]        rd_cnt;
  logic [CNT_W-1:0]        rd_cnt_dec;
  logic [COLCNT_W-1:0]     sw_m1;
  logic [LEVEL_W-1:0]      q0_nxt;
  logic [PROD_W-1:0]       div_rem;
  logic [ADDR_EXT_W-1:0]   col_ext;

  // Clamp the decimation step into 1..4096
  always_comb begin
    if (step_r == '0)          step_eff = STEP_MIN;
    else if (step_r > STEP_MAX) step_eff = STEP_MAX;
    else                       step_eff = step_r;
  end

  // Decimation and column accumulation
  assign in_acc      = in_valid && !in_stall;
  assign col_active  = cur_col_r < COL_LIMIT;
  assign keep        = (dcount_r == '0);
  assign dcount_inc  = {1'b0, dcount_r} + 13'd1;
  assign dcount_wrap = dcount_inc >= step_eff;
  assign kept_inc    = {1'b0, kept_r} + (KEEP_W + 1)'(1);
  assign col_done    = col_active && keep && (kept_inc >= KEEP_LIM);

  // Saturating add of the sample into the 32-bit column sum
  assign sample_ext = {{(SUM_W + 1 - SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
  assign sum_add    = {sum_r[SUM_W-1], sum_r} + sample_ext;
  assign sum_ovf    = sum_add[SUM_W] ^ sum_add[SUM_W-1];
  assign sum_sat    = sum_ovf ? (sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                : {1'b0, {(SUM_W-1){1'b1}}})
                              : sum_add[SUM_W-1:0];

  assign pw_req.start = in_acc && col_done;
  assign pw_req.sum   = $signed(sum_sat);

  abm_power u_power (
    .clk (clk),
    .rst_n (rst_n),
    .req (pw_req),
    .rsp (pw_rsp)
  );

  assign rd_lvl     = rdata_r[MEM_W-1:CNT_W];
  assign rd_cnt     = rdata_r[CNT_W-1:0];
  assign rd_cnt_dec = (rd_cnt != '0) ? (rd_cnt - CNT_W'(1)) : rd_cnt;
  assign sw_m1      = sw_r - COLCNT_W'(1);

  // Decay divide by HOLD_FRAMES: reciprocal estimate, then one correction
  assign q0_nxt  = t_r[RECIP_SH +: LEVEL_W];
  assign div_rem = prod_r - qh_r;

  assign out_free = !out_valid_r || !out_stall;
  assign col_ext  = ADDR_EXT_W'(col_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sw_r == COL_LAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (col_done)          state_nxt = ST_POWER;
          else if (in_frame_end) state_nxt = ST_SWEEP;
        end
      end
      ST_POWER: begin
        if (pw_rsp.done) begin
          if (pw_rsp.level > rd_lvl || rd_cnt == '0) state_nxt = ST_WRITE;
          else                                      state_nxt = ST_DIV_MUL;
        end
      end
      ST_DIV_MUL:  state_nxt = ST_DIV_BACK;
      ST_DIV_BACK: state_nxt = ST_DIV_FIX;
      ST_DIV_FIX:  state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (out_free) state_nxt = sweep_pend_r ? ST_SWEEP : ST_IDLE;
      end
      ST_SWEEP: if (sw_r == COL_LIMIT) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs: handshake, memory ports, result load
  always_comb begin
    in_stall = 1'b1;
    mem_we   = 1'b0;
    mem_wa   = col_r;
    mem_wd   = {new_lvl_r, new_cnt_r};
    mem_re   = 1'b0;
    mem_ra   = cur_col_r[ADDR_W-1:0];
    out_load = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = sw_r[ADDR_W-1:0];
        mem_wd = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        mem_re   = in_valid && col_done;
      end
      ST_WRITE: begin
        mem_we   = out_free;
        out_load = out_free;
      end
      ST_SWEEP: begin
        mem_re = sw_r < COL_LIMIT;
        mem_ra = sw_r[ADDR_W-1:0];
        mem_we = sw_r != '0;
        mem_wa = sw_m1[ADDR_W-1:0];
        mem_wd = {rd_lvl, rd_cnt_dec};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      step_r       <= STEP_MIN;
      dcount_r     <= '0;
      kept_r       <= '0;
      cur_col_r    <= '0;
      sum_r        <= '0;
      sweep_pend_r <= 1'b0;
      sw_r         <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) step_r <= cfg_wr_data;

      if (in_acc) begin
        // Frame end restarts the frame after this sample
        if (in_frame_end) begin
          dcount_r  <= '0;
          kept_r    <= '0;
          cur_col_r <= '0;
          sum_r     <= '0;
        end else if (col_active) begin
          dcount_r <= dcount_wrap ? '0 : dcount_inc[DCOUNT_W-1:0];
          if (keep) begin
            if (col_done) begin
              kept_r    <= '0;
              sum_r     <= '0;
              cur_col_r <= cur_col_r + COLCNT_W'(1);
            end else begin
              kept_r <= kept_inc[KEEP_W-1:0];
              sum_r  <= $signed(sum_sat);
            end
          end
        end
        sweep_pend_r <= in_frame_end;
      end

      // Shared index for the clearing pass and the counter sweep
      case (state_r)
        ST_CLEAR: sw_r <= (sw_r == COL_LAST) ? '0 : sw_r + COLCNT_W'(1);
        ST_SWEEP: sw_r <= (sw_r == COL_LIMIT) ? '0 : sw_r + COLCNT_W'(1);
        default:  sw_r <= '0;
      endcase

      if (out_load)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Column update datapath
  always_ff @(posedge clk) begin
    if (in_acc && col_done) begin
      col_r  <= cur_col_r[ADDR_W-1:0];
      last_r <= (cur_col_r == COL_LAST);
    end
    case (state_r)
      ST_POWER: begin
        if (pw_rsp.done) begin
          if (pw_rsp.level > rd_lvl) begin
            new_lvl_r <= pw_rsp.level;
            new_cnt_r <= HOLD_CNT;
          end else begin
            new_lvl_r <= '0;
            new_cnt_r <= rd_cnt;
          end
          prod_r <= {{CNT_W{1'b0}}, rd_lvl} * {{LEVEL_W{1'b0}}, rd_cnt - CNT_W'(1)};
        end
      end
      ST_DIV_MUL: begin
        t_r <= {{RECIP_W{1'b0}}, prod_r} * {{PROD_W{1'b0}}, RECIP};
      end
      ST_DIV_BACK: begin
        q0_r <= q0_nxt;
        qh_r <= {{CNT_W{1'b0}}, q0_nxt} * {{LEVEL_W{1'b0}}, HOLD_CNT};
      end
      ST_DIV_FIX: begin
        new_lvl_r <= q0_r + LEVEL_W'(div_rem >= {{LEVEL_W{1'b0}}, HOLD_CNT});
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_col_r  <= col_ext[COL_IDX_W-1:0];
      out_lvl_r  <= new_lvl_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_index = out_col_r;
  assign out_bar_level    = out_lvl_r;
  assign out_last_column  = out_last_r;

endmodule

`default_nettype wire

@@ verif/audio_bar_meter_peak_decay_top_tb.sv @@
// Self-checking testbench for the audio bar meter with peak hold and decay.
module audio_bar_meter_peak_decay_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizing follows the block's defaults
  localparam int COLUMNS     = abm_pkg::COLUMNS_DEF;
  localparam int POINTS      = abm_pkg::POINTS_DEF;
  localparam int HOLD_FRAMES = abm_pkg::HOLD_FRAMES_DEF;
  localparam int SAMPLE_W    = abm_pkg::SAMPLE_BITS_DEF;
  localparam int PER_COLUMN  = (POINTS / COLUMNS) > 0 ? (POINTS / COLUMNS) : 1;
  localparam int LEVEL_W     = abm_pkg::LEVEL_W;
  localparam int COL_W       = abm_pkg::COL_IDX_W;
  localparam int STEP_W      = abm_pkg::STEP_W;

  // 1.5e-7 as an unsigned Q48 factor; x^0.45 is done as 20*log(y) <= 9*log(x) - 152
  localparam logic [63:0] SCALE_1P5E7 = 64'd42221247;
  localparam longint      LOG_OFFSET  = 152 * 65536;
  localparam longint      SUM_HI      = 64'sd2147483647;
  localparam longint      SUM_LO      = -64'sd2147483648;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam int SETTLE_CYCLES  = 600;    // covers a column update plus a frame-end sweep
  localparam int HOLDOFF_CYCLES = 3000;
  localparam int DRAIN_LIMIT    = 50000;
  localparam int TARGET_SAMPLES = 1900;

  localparam string PASS_MSG = "Testbench completed without errors";
  localparam string FAIL_MSG = "Testbench completed WITH ERRORS";

  typedef enum int unsigned {AMP_FULL, AMP_SMALL, AMP_LOUD, AMP_NEG, AMP_COUNT} amp_t;

  typedef struct {
    logic [COL_W-1:0]   column;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } bar_update_t;

  // DUT connections; every input known from time zero
  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample    = '0;
  logic                in_frame_end = 1'b0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [COL_W-1:0]    out_column_index;
  logic [LEVEL_W-1:0]  out_bar_level;
  logic                out_last_column;
  logic                cfg_wr_en    = 1'b0;
  logic [STEP_W-1:0]   cfg_wr_data  = '0;

  // Shadow state of the meter
  logic [LEVEL_W-1:0] col_level [COLUMNS] = '{default: '0};
  int unsigned        hold_frames [COLUMNS] = '{default: 0};
  int unsigned        decim_pos  = 0;
  int unsigned        kept_count = 0;
  int unsigned        col_ptr    = 0;
  longint             col_sum    = 0;
  logic [STEP_W-1:0]  step_reg   = abm_pkg::STEP_MIN;

  bar_update_t levels_due [$];
  int unsigned mismatches   = 0;
  int unsigned samples_sent = 0;

  // Traffic shaping shared with the stall process
  bit          calm          = 1'b0;
  int unsigned hold_ticket   = 0;
  int unsigned hold_seen     = 0;
  int unsigned holdoff_count = 0;

  audio_bar_meter_peak_decay_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_frame_end     (in_frame_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_index (out_column_index),
    .out_bar_level    (out_bar_level),
    .out_last_column  (out_last_column),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Level computation
  // ---------------------------------------------------------------------------

  // log2 with 16 fraction bits: msb position, then one fraction bit per squaring
  // of the Q31 mantissa (truncating).
  function automatic longint fix_log2(input logic [63:0] v);
    int          p;
    logic [63:0] m;
    longint      frac;
    if (v == '0) return 0;
    p = 63;
    while (!v[p]) p--;
    if (p >= 31) m = v >> (p - 31);
    else m = v << (31 - p);
    frac = 0;
    repeat (16) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m[63:32] != '0) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(p) << 16) | frac;
  endfunction

  // (sum * 1.5e-7)^0.45 in Q14: largest y that passes the log compare.
  function automatic logic [LEVEL_W-1:0] meter_power(input longint total);
    logic [63:0] scaled;
    longint      bound;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (total <= 0) return '0;
    scaled = total;
    scaled = scaled * SCALE_1P5E7;
    bound = 9 * fix_log2(scaled) - LOG_OFFSET;
    lo = 0;
    hi = 65535;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (20 * fix_log2(64'(mid)) <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo[LEVEL_W-1:0];
  endfunction

  // Zero acts as 1, anything past the cap as the cap.
  function automatic int unsigned step_in_use();
    if (step_reg == '0) return 1;
    if (step_reg > abm_pkg::STEP_MAX) return abm_pkg::STEP_MAX;
    return step_reg;
  endfunction

  // Advance the shadow meter by one sample; return 1 when a column completes.
  function automatic bit meter_step(input logic signed [SAMPLE_W-1:0] smp, input bit fe,
                                    output bar_update_t upd);
    int unsigned        c;
    bit                 keep;
    bit                 made;
    logic [LEVEL_W-1:0] val;
    longint             lvl;
    made = 1'b0;
    upd.column = '0;
    upd.level  = '0;
    upd.last   = 1'b0;
    if (col_ptr < COLUMNS) begin
      keep = (decim_pos == 0);
      decim_pos++;
      if (decim_pos >= step_in_use()) decim_pos = 0;
      if (keep) begin
        col_sum = col_sum + smp;
        if (col_sum > SUM_HI) col_sum = SUM_HI;
        if (col_sum < SUM_LO) col_sum = SUM_LO;
        kept_count++;
        if (kept_count >= PER_COLUMN) begin
          c   = col_ptr;
          val = meter_power(col_sum);
          lvl = col_level[c];
          if (val > lvl) begin
            lvl = val;
            hold_frames[c] = HOLD_FRAMES;
          end else if (hold_frames[c] == 0) begin
            lvl = 0;
          end else begin
            lvl = (lvl * (longint'(hold_frames[c]) - 1)) / HOLD_FRAMES;
          end
          col_level[c] = lvl[LEVEL_W-1:0];
          upd.column = c[COL_W-1:0];
          upd.level  = col_level[c];
          upd.last   = (c == COLUMNS - 1);
          made = 1'b1;
          col_ptr++;
          kept_count = 0;
          col_sum = 0;
        end
      end
    end
    // frame end: age the hold counters and restart the frame
    if (fe) begin
      for (int i = 0; i < COLUMNS; i++)
        if (hold_frames[i] != 0) hold_frames[i]--;
      decim_pos  = 0;
      kept_count = 0;
      col_ptr    = 0;
      col_sum    = 0;
    end
    return made;
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(input amp_t amp);
    logic [SAMPLE_W-1:0] r;
    r = SAMPLE_W'($urandom);
    case (amp)
      AMP_SMALL: r = SAMPLE_W'($urandom_range(0, 2047)) - SAMPLE_W'(1024);
      AMP_LOUD:  r[SAMPLE_W-1 -: 2] = 2'b01;
      AMP_NEG:   r[SAMPLE_W-1] = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one sample; hold it until accepted, then record the expected column update.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit fe);
    bar_update_t upd;
    if (!calm) begin
      while ($urandom_range(99) < 28) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_sample    <= smp;
    in_frame_end <= fe;
    do begin
      @(posedge clk);
    end while (in_stall);
    if (meter_step(smp, fe, upd)) levels_due = {levels_due, upd};
    samples_sent++;
  endtask

  // Drop valid and wait until every expected column update has come out.
  task automatic await_results();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (levels_due.size() != 0);
  endtask

  // Write the decimation step once the block has gone idle.
  task automatic write_step(input logic [STEP_W-1:0] value);
    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_reg = value;
  endtask

  // Receiver: a requested hold-off wins; otherwise stall at random unless calm.
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      holdoff_count = HOLDOFF_CYCLES;
    end
    if (holdoff_count > 0) begin
      holdoff_count--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 28);
    end
  end

  // Compare every accepted result with the oldest pending expectation.
  always @(posedge clk) begin
    bar_update_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (levels_due.size() == 0) begin
        report_mismatch("unexpected result, column", out_column_index, -1);
      end else begin
        want = levels_due.pop_front();
        if (out_column_index !== want.column)
          report_mismatch("column_index", out_column_index, want.column);
        if (out_bar_level !== want.level)
          report_mismatch("bar_level", out_bar_level, want.level);
        if (out_last_column !== want.last)
          report_mismatch("last_column", out_last_column, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Full-scale columns at the reset step of 1, then a partial column dropped by frame end.
  task automatic test_extreme_samples();
    repeat (PER_COLUMN) send_sample(SAMPLE_MAX, 1'b0);
    repeat (PER_COLUMN) send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(SAMPLE_W'(1), 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
  endtask

  // Step of zero acts as 1, an oversized step as the cap; a frame end on the
  // completing sample still yields its column.
  task automatic test_step_limits();
    write_step('0);
    repeat (PER_COLUMN - 1) send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    write_step('1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    write_step(STEP_W'(2));
    for (int i = 0; i < 2 * PER_COLUMN; i++)
      send_sample(draw_sample(AMP_LOUD), i == 2 * PER_COLUMN - 1);
  endtask

  // One frame through every column plus ignored overflow samples. Run the first
  // half without idling, pause for the results, then hold off the receiver long
  // enough that the block backs up and stalls its input.
  task automatic test_full_frame();
    int n;
    n = COLUMNS * PER_COLUMN + 4;
    write_step(abm_pkg::STEP_MIN);
    calm = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        calm = 1'b0;
        await_results();
      end
      if (i == (3 * n) / 5) hold_ticket++;
      send_sample(draw_sample(amp_t'($urandom_range(0, AMP_COUNT - 1))), i == n - 1);
    end
  endtask

  // Age all hold counters to zero with short frames; column 0 keeps decaying on
  // silent columns, and at the end a counter of zero forces the level to zero.
  task automatic test_hold_expiry();
    for (int f = 0; f < HOLD_FRAMES + 5; f++) begin
      if ($urandom_range(9) == 0) begin
        for (int k = 0; k < PER_COLUMN; k++)
          send_sample(draw_sample(AMP_NEG), k == PER_COLUMN - 1);
      end else begin
        send_sample(draw_sample(AMP_FULL), 1'b1);
      end
    end
    for (int k = 0; k < 2 * PER_COLUMN; k++)
      send_sample(draw_sample(AMP_NEG), k == 2 * PER_COLUMN - 1);
  endtask

  // Mostly whole columns at varied steps and loudness, some torn frames and
  // some frames at steps too large to finish a column.
  task automatic test_random_frames();
    int unsigned eff;
    int unsigned len;
    amp_t        amp;
    while (samples_sent < TARGET_SAMPLES) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(7))
          3: write_step(STEP_W'(2));
          4: write_step(STEP_W'(3));
          5: write_step(STEP_W'($urandom_range(4, 8)));
          6: write_step('0);
          7: write_step($urandom_range(1) ? abm_pkg::STEP_MAX
                                          : STEP_W'($urandom_range(4097, 8191)));
          default: write_step(abm_pkg::STEP_MIN);
        endcase
      end
      eff = step_in_use();
      amp = amp_t'($urandom_range(0, AMP_COUNT - 1));
      if (eff > 16 || $urandom_range(9) == 0) begin
        len = $urandom_range(1, 10);
      end else begin
        len = PER_COLUMN * eff * $urandom_range(1, 8);
        if ($urandom_range(2) == 0) len += $urandom_range(0, PER_COLUMN * eff - 1);
      end
      calm = ($urandom_range(7) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) < 7) send_sample(draw_sample(amp), i == len - 1);
        else send_sample(draw_sample(amp_t'($urandom_range(0, AMP_COUNT - 1))), i == len - 1);
      end
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_extreme_samples();
    test_step_limits();
    test_full_frame();
    test_hold_expiry();
    test_random_frames();
    // drain: wait for the outstanding transactions, then let the block settle
    in_valid <= 1'b0;
    waited = 0;
    while (levels_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (levels_due.size() != 0)
      report_mismatch("results never arrived, count", levels_due.size(), 0);
    if (mismatches == 0) begin
      $display(PASS_MSG);
    end else begin
      $display(FAIL_MSG);
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(50ms);
    $display(FAIL_MSG);
    $finish;
  end

endmodule
